// ----- design/lrip_pkg.sv -----
// ----------------------------------------------------------------------------
// lrip_pkg
// Shared widths, register indexes, CORDIC arctangent table and item types
// of the lidar range image projection block.
// ----------------------------------------------------------------------------
package lrip_pkg;

    localparam int XW        = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 24;

    localparam int SQD_RW  = 21;
    localparam int SQXY_RW = 28;
    localparam int CW      = 32;
    localparam int AW      = 26;
    localparam int PW      = 27;
    localparam int TAB_LEN = 24;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_ROWS          = 128;
    localparam int MAX_COLUMNS       = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LINES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_FOV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_SCALE   = 3'd5;

    localparam logic signed [AW-1:0] DEG90_A = 26'sd5898240;
    localparam logic signed [PW-1:0] DEG90_E = 27'sd5898240;

    localparam logic [AW-1:0] ATAN_TAB [TAB_LEN] = '{
        26'd2949120, 26'd1740967, 26'd919879, 26'd466945,
        26'd234379,  26'd117304,  26'd58666,  26'd29335,
        26'd14668,   26'd7334,    26'd3667,   26'd1833,
        26'd917,     26'd458,     26'd229,    26'd115,
        26'd57,      26'd29,      26'd14,     26'd7,
        26'd4,       26'd2,       26'd1,      26'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [AW-1:0] ang;
    } t_cordic;

    typedef struct packed {
        logic                 keep;
        logic [6:0]           row;
        logic [11:0]          column;
        logic [18:0]          cell_index;
        logic [19:0]          distance;
        logic signed [XW-1:0] out_x;
        logic signed [XW-1:0] out_y;
        logic signed [XW-1:0] out_z;
    } t_result;

endpackage

// ----- design/lrip_delay.sv -----
// ----------------------------------------------------------------------------
// lrip_delay
// Enabled shift line that aligns side data with the cell chains.
// ----------------------------------------------------------------------------
module lrip_delay #(
    parameter int W   = 8,
    parameter int LEN = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [LEN];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < LEN; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[LEN-1];
endmodule

// ----- design/lrip_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// lrip_sqrt_cell
// One restoring square-root cell: settles one root bit per item and hands
// remainder, partial root and remaining radicand bits to the next cell.
// ----------------------------------------------------------------------------
module lrip_sqrt_cell #(
    parameter int RW = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root,
    output logic [2*RW-1:0] o_rad
);
    logic [RW+3:0]   w_sh;
    logic [RW+3:0]   w_trial;
    logic            w_ge;
    logic [RW+3:0]   w_diff;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [2*RW-1:0] r_rad;

    assign w_sh    = {i_rem, i_rad[2*RW-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);
    assign w_diff  = w_ge ? (w_sh - w_trial) : w_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_diff[RW+1:0];
            r_root <= {i_root[RW-2:0], w_ge};
            r_rad  <= {i_rad[2*RW-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
endmodule

// ----- design/lrip_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// lrip_cordic_cell
// One vectoring CORDIC micro-rotation: rotate toward b = 0 and
// accumulate the matching arctangent.
// ----------------------------------------------------------------------------
module lrip_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  lrip_pkg::t_cordic i_v,
    output lrip_pkg::t_cordic o_v
);
    import lrip_pkg::*;

    logic signed [CW-1:0] w_sa;
    logic signed [CW-1:0] w_sb;
    logic signed [AW-1:0] w_step;
    t_cordic              n_v;
    t_cordic              r_v;

    assign w_sa   = $signed(i_v.a) >>> SHIFT;
    assign w_sb   = $signed(i_v.b) >>> SHIFT;
    assign w_step = $signed(ATAN_TAB[SHIFT]);

    always_comb begin
        if ($signed(i_v.b) > 0) begin
            n_v.a   = i_v.a + w_sb;
            n_v.b   = i_v.b - w_sa;
            n_v.ang = i_v.ang + w_step;
        end else begin
            n_v.a   = i_v.a - w_sb;
            n_v.b   = i_v.b + w_sa;
            n_v.ang = i_v.ang - w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;
endmodule

// ----- design/lidar_range_image_projection.sv -----
// ----------------------------------------------------------------------------
// lidar_range_image_projection
// Projects one lidar point per item onto a cell of a range image.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with the point i_px, i_py, i_pz.
// Output channel: o_out_valid / i_out_stall with keep, row, column,
// cell index, rounded range and the point passed through.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
// picks the register, i_cfg_data carries the value; unknown indexes are
// ignored. Write only while the block holds no item.
// Throughput: one item per cycle while o_in_stall is low. From acceptance to
// o_out_valid an item passes the 28-cell horizontal-radius square-root chain,
// then the elevation CORDIC chain and the row/column scaling stages.
// Reset: synchronous, active low; empties the pipeline and loads the
// register defaults.
// Output stall: an output register plus one skid entry; o_in_stall rises
// only when the skid entry is full, and the whole chain then holds.
// ----------------------------------------------------------------------------
module lidar_range_image_projection #(
    parameter int CORDIC_STAGES = lrip_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lrip_pkg::XW-1:0]      i_px,
    input  logic signed [lrip_pkg::XW-1:0]      i_py,
    input  logic signed [lrip_pkg::XW-1:0]      i_pz,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_keep,
    output logic [6:0]                          o_row,
    output logic [11:0]                         o_column,
    output logic [18:0]                         o_cell_index,
    output logic [19:0]                         o_distance,
    output logic signed [lrip_pkg::XW-1:0]      o_out_x,
    output logic signed [lrip_pkg::XW-1:0]      o_out_y,
    output logic signed [lrip_pkg::XW-1:0]      o_out_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrip_pkg::CFG_DW-1:0]         i_cfg_data
);
    import lrip_pkg::*;

    localparam int N      = CORDIC_STAGES;
    localparam int DEPTH  = SQXY_RW + N + 6;
    localparam int DLEN   = SQXY_RW - SQD_RW + N + 3;
    localparam int PTW    = 3 * XW;

    // configuration registers
    logic [7:0]  r_scan_lines;
    logic [7:0]  r_target_rows;
    logic [12:0] r_columns;
    logic [14:0] r_hfov;
    logic [23:0] r_row_scale;
    logic [23:0] r_col_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_lines  <= 8'd16;
            r_target_rows <= 8'd16;
            r_columns     <= 13'd900;
            r_hfov        <= 15'd3840;
            r_row_scale   <= 24'd32768;
            r_col_scale   <= 24'd163840;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCAN_LINES:  r_scan_lines  <= i_cfg_data[7:0];
                CFG_TARGET_ROWS: r_target_rows <= i_cfg_data[7:0];
                CFG_COLUMNS:     r_columns     <= i_cfg_data[12:0];
                CFG_HALF_FOV:    r_hfov        <= i_cfg_data[14:0];
                CFG_ROW_SCALE:   r_row_scale   <= i_cfg_data;
                CFG_COL_SCALE:   r_col_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // flow control
    logic             r_skid_full;
    logic             w_en;
    logic             w_in_acc;
    logic [DEPTH-1:0] r_vld;

    assign w_en       = !r_skid_full;
    assign o_in_stall = r_skid_full;
    assign w_in_acc   = i_in_valid && !r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], w_in_acc};
        end
    end

    // stage 1: squares and azimuth pre-rotation
    logic signed [39:0] w_xx, w_yy, w_zz;
    logic signed [CW-1:0] w_ya, w_xb;
    t_cordic              w_pre;
    logic [38:0]          r1_xx, r1_yy, r1_zz;
    t_cordic              r1_az;
    logic [PTW-1:0]       r1_pt;

    assign w_xx = 40'(i_px) * 40'(i_px);
    assign w_yy = 40'(i_py) * 40'(i_py);
    assign w_zz = 40'(i_pz) * 40'(i_pz);
    assign w_ya = {{4{i_py[XW-1]}}, i_py, 8'd0};
    assign w_xb = {{4{i_px[XW-1]}}, i_px, 8'd0};

    always_comb begin
        if (w_ya < 0) begin
            if (w_xb >= 0) begin
                w_pre.a   = w_xb;
                w_pre.b   = -w_ya;
                w_pre.ang = DEG90_A;
            end else begin
                w_pre.a   = -w_xb;
                w_pre.b   = w_ya;
                w_pre.ang = -DEG90_A;
            end
        end else begin
            w_pre.a   = w_ya;
            w_pre.b   = w_xb;
            w_pre.ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_xx <= w_xx[38:0];
            r1_yy <= w_yy[38:0];
            r1_zz <= w_zz[38:0];
            r1_az <= w_pre;
            r1_pt <= {i_px, i_py, i_pz};
        end
    end

    // stage 2: sums of squares
    logic [39:0]    r2_sxy;
    logic [40:0]    r2_s3;
    t_cordic        r2_az;
    logic [PTW-1:0] r2_pt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sxy <= {1'b0, r1_xx} + {1'b0, r1_yy};
            r2_s3  <= {2'b00, r1_xx} + {2'b00, r1_yy} + {2'b00, r1_zz};
            r2_az  <= r1_az;
            r2_pt  <= r1_pt;
        end
    end

    // range square-root chain
    logic [SQD_RW+1:0]   w_drem  [SQD_RW+1];
    logic [SQD_RW-1:0]   w_droot [SQD_RW+1];
    logic [2*SQD_RW-1:0] w_drad  [SQD_RW+1];

    assign w_drem[0]  = '0;
    assign w_droot[0] = '0;
    assign w_drad[0]  = {1'b0, r2_s3};

    for (genvar j = 0; j < SQD_RW; j++) begin : g_dsq
        lrip_sqrt_cell #(.RW(SQD_RW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_drem[j]),
            .i_root (w_droot[j]),
            .i_rad  (w_drad[j]),
            .o_rem  (w_drem[j+1]),
            .o_root (w_droot[j+1]),
            .o_rad  (w_drad[j+1])
        );
    end

    // horizontal radius square-root chain, 8 fraction bits
    logic [SQXY_RW+1:0]   w_xrem  [SQXY_RW+1];
    logic [SQXY_RW-1:0]   w_xroot [SQXY_RW+1];
    logic [2*SQXY_RW-1:0] w_xrad  [SQXY_RW+1];

    assign w_xrem[0]  = '0;
    assign w_xroot[0] = '0;
    assign w_xrad[0]  = {r2_sxy, 16'd0};

    for (genvar j = 0; j < SQXY_RW; j++) begin : g_xsq
        lrip_sqrt_cell #(.RW(SQXY_RW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_xrem[j]),
            .i_root (w_xroot[j]),
            .i_rad  (w_xrad[j]),
            .o_rem  (w_xrem[j+1]),
            .o_root (w_xroot[j+1]),
            .o_rad  (w_xrad[j+1])
        );
    end

    // range rounding and saturation
    logic [SQD_RW:0] w_dinc;
    logic [19:0]     w_dist;
    logic            w_nz;
    logic [20:0]     w_dd;

    assign w_dinc = {1'b0, w_droot[SQD_RW]}
                  + {{SQD_RW{1'b0}}, (w_drem[SQD_RW] > {2'b00, w_droot[SQD_RW]})};
    assign w_dist = (w_dinc > 22'hFFFFF) ? 20'hFFFFF : w_dinc[19:0];
    assign w_nz   = |w_droot[SQD_RW];

    lrip_delay #(.W(21), .LEN(DLEN)) u_ddel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_nz, w_dist}),
        .o_q   (w_dd)
    );

    // z aligned with the horizontal radius
    logic signed [XW-1:0] w_zal;

    lrip_delay #(.W(XW), .LEN(SQXY_RW)) u_zdel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r2_pt[XW-1:0]),
        .o_q   (w_zal)
    );

    // elevation CORDIC chain
    t_cordic w_el [N+1];

    assign w_el[0].a   = {{(CW-SQXY_RW){1'b0}}, w_xroot[SQXY_RW]};
    assign w_el[0].b   = {{4{w_zal[XW-1]}}, w_zal, 8'd0};
    assign w_el[0].ang = '0;

    for (genvar i = 0; i < N; i++) begin : g_el
        lrip_cordic_cell #(.SHIFT(i)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (w_el[i]),
            .o_v   (w_el[i+1])
        );
    end

    // azimuth CORDIC chain
    t_cordic              w_az [N+1];
    logic signed [AW-1:0] w_azd;

    assign w_az[0] = r2_az;

    for (genvar i = 0; i < N; i++) begin : g_az
        lrip_cordic_cell #(.SHIFT(i)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (w_az[i]),
            .o_v   (w_az[i+1])
        );
    end

    lrip_delay #(.W(AW), .LEN(SQXY_RW)) u_azdel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_az[N].ang),
        .o_q   (w_azd)
    );

    logic [PTW-1:0] w_pt;

    lrip_delay #(.W(PTW), .LEN(SQXY_RW + N)) u_ptdel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r2_pt),
        .o_q   (w_pt)
    );

    // scaling stage 1: signed offsets to magnitude and sign
    logic signed [PW-1:0] w_d, w_e, w_azx;
    logic                 w_xyzero;
    logic                 r_r1_rneg, r_r1_cneg;
    logic [PW-1:0]        r_r1_rmag, r_r1_cmag;
    logic [PTW-1:0]       r_r1_pt;

    assign w_d      = $signed({4'd0, r_hfov, 8'd0})
                    - $signed({w_el[N].ang[AW-1], w_el[N].ang});
    assign w_xyzero = (w_pt[PTW-1 -: XW] == '0) && (w_pt[2*XW-1 -: XW] == '0);
    assign w_azx    = w_xyzero ? '0 : {w_azd[AW-1], w_azd};
    assign w_e      = w_azx - DEG90_E;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_rneg <= w_d[PW-1];
            r_r1_rmag <= w_d[PW-1] ? -w_d : w_d;
            r_r1_cneg <= w_e[PW-1];
            r_r1_cmag <= w_e[PW-1] ? -w_e : w_e;
            r_r1_pt   <= w_pt;
        end
    end

    // scaling stage 2: products
    logic [PW+23:0] r_r2_rprod, r_r2_cprod;
    logic           r_r2_rneg, r_r2_cneg;
    logic [PTW-1:0] r_r2_pt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2_rprod <= {24'd0, r_r1_rmag} * {{PW{1'b0}}, r_row_scale};
            r_r2_cprod <= {24'd0, r_r1_cmag} * {{PW{1'b0}}, r_col_scale};
            r_r2_rneg  <= r_r1_rneg;
            r_r2_cneg  <= r_r1_cneg;
            r_r2_pt    <= r_r1_pt;
        end
    end

    // scaling stage 3: round, place, range check
    logic [PW+24:0]     w_rsum, w_csum;
    logic [19:0]        w_rq, w_cq;
    logic signed [20:0] w_row;
    logic               w_row_ok;
    logic signed [21:0] w_h, w_col0, w_col1;
    logic               w_col_ok;
    logic [6:0]         r_r3_row;
    logic [11:0]        r_r3_col;
    logic               r_r3_row_ok, r_r3_col_ok;
    logic [PTW-1:0]     r_r3_pt;

    assign w_rsum = {1'b0, r_r2_rprod} + 52'h8000_0000;
    assign w_csum = {1'b0, r_r2_cprod} + 52'h8000_0000;
    assign w_rq   = w_rsum[51:32];
    assign w_cq   = w_csum[51:32];

    always_comb begin
        if (r_scan_lines <= 8'd1) begin
            w_row = '0;
        end else if (r_r2_rneg) begin
            w_row = -$signed({1'b0, w_rq});
        end else begin
            w_row = $signed({1'b0, w_rq});
        end
    end

    assign w_row_ok = !w_row[20]
                    && (w_row[19:0] < {12'd0, r_target_rows})
                    && (w_row[19:0] < 20'(MAX_ROWS));

    assign w_h    = $signed({9'd0, r_columns});
    assign w_col0 = $signed({10'd0, r_columns[12:1]})
                  + (r_r2_cneg ? $signed({2'b00, w_cq}) : -$signed({2'b00, w_cq}));
    assign w_col1 = (w_col0 >= w_h) ? (w_col0 - w_h) : w_col0;
    assign w_col_ok = !w_col1[21] && (w_col1 < w_h) && (w_col1 < 22'(MAX_COLUMNS));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r3_row    <= w_row[6:0];
            r_r3_row_ok <= w_row_ok;
            r_r3_col    <= w_col1[11:0];
            r_r3_col_ok <= w_col_ok;
            r_r3_pt     <= r_r2_pt;
        end
    end

    // final stage: keep decision and cell index
    logic    w_keep;
    logic [19:0] w_rh;
    logic [19:0] w_cell;
    t_result r_fin;

    assign w_keep = w_dd[20] && r_r3_row_ok && r_r3_col_ok;
    assign w_rh   = {13'd0, r_r3_row} * {7'd0, r_columns};
    assign w_cell = w_rh + {8'd0, r_r3_col};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin.keep       <= w_keep;
            r_fin.row        <= w_keep ? r_r3_row : '0;
            r_fin.column     <= w_keep ? r_r3_col : '0;
            r_fin.cell_index <= w_keep ? w_cell[18:0] : '0;
            r_fin.distance   <= w_dd[19:0];
            r_fin.out_x      <= r_r3_pt[PTW-1 -: XW];
            r_fin.out_y      <= r_r3_pt[2*XW-1 -: XW];
            r_fin.out_z      <= r_r3_pt[XW-1:0];
        end
    end

    // output register and skid entry
    logic    w_pipe_out;
    logic    w_out_free;
    logic    r_out_valid;
    t_result r_out;
    t_result r_skid;

    assign w_pipe_out = r_vld[DEPTH-1] && w_en;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_full) begin
                r_out_valid <= 1'b1;
                r_skid_full <= 1'b0;
            end else begin
                r_out_valid <= w_pipe_out;
            end
        end else if (w_pipe_out) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_full ? r_skid : r_fin;
        end else if (w_pipe_out) begin
            r_skid <= r_fin;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_keep       = r_out.keep;
    assign o_row        = r_out.row;
    assign o_column     = r_out.column;
    assign o_cell_index = r_out.cell_index;
    assign o_distance   = r_out.distance;
    assign o_out_x      = r_out.out_x;
    assign o_out_y      = r_out.out_y;
    assign o_out_z      = r_out.out_z;
endmodule
